[rtl/core/dfm_pkg.sv]
// Package for the debounced fault monitor: config struct, register indexes,
// reset values, fault codes and port widths. No dependencies.
`timescale 1ns / 1ps

package dfm_pkg;

  // Default counter width.
  localparam int COUNT_BITS_DEF = 8;

  // Field widths.
  localparam int GAS_W     = 10;
  localparam int TEMP_W    = 16;
  localparam int PERSIST_W = 8;

  // Stream data widths (packed fields rounded up to whole bytes).
  localparam int IN_FIELDS_W  = GAS_W + 1 + TEMP_W + 3;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_GAS_HIGH_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_VALID_MAX  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANALOG_PERSIST  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIN_PERSIST     = 3'd4;

  // Reset values.
  localparam logic [GAS_W-1:0]     GAS_HIGH_LIMIT_RST  = 10'h300;
  localparam logic [TEMP_W-1:0]    TEMP_HIGH_LIMIT_RST = 16'd800;
  localparam logic [TEMP_W-1:0]    TEMP_VALID_MAX_RST  = 16'd1200;
  localparam logic [PERSIST_W-1:0] ANALOG_PERSIST_RST  = 8'd20;
  localparam logic [PERSIST_W-1:0] PIN_PERSIST_RST     = 8'd10;

  typedef struct packed {
    logic [GAS_W-1:0]     gas_high_limit;
    logic [TEMP_W-1:0]    temp_high_limit;
    logic [TEMP_W-1:0]    temp_valid_max;
    logic [PERSIST_W-1:0] analog_persist_count;
    logic [PERSIST_W-1:0] pin_persist_count;
  } cfg_t;

  typedef struct packed {
    logic [GAS_W-1:0]  gas_sample;
    logic              gas_timeout;
    logic [TEMP_W-1:0] temp_reading;
    logic              store_level_ok;
    logic              second_level_ok;
    logic              leak_ok;
  } sample_t;

  typedef enum logic [2:0] {
    FC_SAFE         = 3'd0,
    FC_GAS_FAIL     = 3'd1,
    FC_GAS_HIGH     = 3'd2,
    FC_TEMP_HIGH    = 3'd3,
    FC_TEMP_FAIL    = 3'd4,
    FC_STORE_LOW    = 3'd5,
    FC_SECOND_LEVEL = 3'd6,
    FC_LEAK         = 3'd7
  } fault_code_t;

endpackage

[rtl/core/dfm_cfg.sv]
// Configuration register file of the fault monitor.
// Depends on dfm_pkg.
`timescale 1ns / 1ps

module dfm_cfg
  import dfm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gas_high_limit       <= GAS_HIGH_LIMIT_RST;
      cfg_r.temp_high_limit      <= TEMP_HIGH_LIMIT_RST;
      cfg_r.temp_valid_max       <= TEMP_VALID_MAX_RST;
      cfg_r.analog_persist_count <= ANALOG_PERSIST_RST;
      cfg_r.pin_persist_count    <= PIN_PERSIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAS_HIGH_LIMIT:  cfg_r.gas_high_limit       <= cfg_wdata[GAS_W-1:0];
        CFG_TEMP_HIGH_LIMIT: cfg_r.temp_high_limit      <= cfg_wdata[TEMP_W-1:0];
        CFG_TEMP_VALID_MAX:  cfg_r.temp_valid_max       <= cfg_wdata[TEMP_W-1:0];
        CFG_ANALOG_PERSIST:  cfg_r.analog_persist_count <= cfg_wdata[PERSIST_W-1:0];
        CFG_PIN_PERSIST:     cfg_r.pin_persist_count    <= cfg_wdata[PERSIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/dfm_check.sv]
// Persistence counters and prioritized fault checks of the fault monitor.
// Depends on dfm_pkg.
`timescale 1ns / 1ps

module dfm_check
  import dfm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  sample_t     smp,
  input  logic        commit,   // counters take their new values
  output fault_code_t code
);

  // Compare width covers both the counter and the 8-bit persistence limit.
  localparam int CMP_W = (COUNT_BITS > PERSIST_W) ? COUNT_BITS : PERSIST_W;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  cnt_t gas_fail_r,  gas_fail_nxt;
  cnt_t gas_high_r,  gas_high_nxt;
  cnt_t temp_high_r, temp_high_nxt;
  cnt_t temp_fail_r, temp_fail_nxt;
  cnt_t store_r,     store_nxt;
  cnt_t second_r,    second_nxt;
  cnt_t leak_r,      leak_nxt;

  fault_code_t code_c;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : cnt_t'(c + 1'b1);
  endfunction

  function automatic logic reached(input cnt_t c, input logic [PERSIST_W-1:0] lim);
    reached = (CMP_W'(c) >= CMP_W'(lim));
  endfunction

  always_comb begin
    logic done;
    logic temp_bad;
    done          = 1'b0;
    code_c        = FC_SAFE;
    gas_fail_nxt  = gas_fail_r;
    gas_high_nxt  = gas_high_r;
    temp_high_nxt = temp_high_r;
    temp_fail_nxt = temp_fail_r;
    store_nxt     = store_r;
    second_nxt    = second_r;
    leak_nxt      = leak_r;
    temp_bad      = (smp.temp_reading > cfg.temp_valid_max) || (smp.temp_reading == '0);

    // gas: timeout beats high sample
    if (smp.gas_timeout) begin
      gas_fail_nxt = sat_inc(gas_fail_r);
      if (reached(gas_fail_nxt, cfg.analog_persist_count)) begin
        done   = 1'b1;
        code_c = FC_GAS_FAIL;
      end
    end else if (smp.gas_sample >= cfg.gas_high_limit) begin
      gas_high_nxt = sat_inc(gas_high_r);
      if (reached(gas_high_nxt, cfg.analog_persist_count)) begin
        done   = 1'b1;
        code_c = FC_GAS_HIGH;
      end
    end else begin
      gas_fail_nxt = '0;
      gas_high_nxt = '0;
    end

    // temperature: read failure beats high
    if (!done) begin
      if (temp_bad) begin
        temp_fail_nxt = sat_inc(temp_fail_r);
        if (reached(temp_fail_nxt, cfg.analog_persist_count)) begin
          done   = 1'b1;
          code_c = FC_TEMP_FAIL;
        end
      end else if (smp.temp_reading > cfg.temp_high_limit) begin
        temp_high_nxt = sat_inc(temp_high_r);
        if (reached(temp_high_nxt, cfg.analog_persist_count)) begin
          done   = 1'b1;
          code_c = FC_TEMP_HIGH;
        end
      end else begin
        temp_high_nxt = '0;
        temp_fail_nxt = '0;
      end
    end

    if (!done) begin
      if (!smp.store_level_ok) begin
        store_nxt = sat_inc(store_r);
        if (reached(store_nxt, cfg.pin_persist_count)) begin
          done   = 1'b1;
          code_c = FC_STORE_LOW;
        end
      end else begin
        store_nxt = '0;
      end
    end

    if (!done) begin
      if (!smp.second_level_ok) begin
        second_nxt = sat_inc(second_r);
        if (reached(second_nxt, cfg.pin_persist_count)) begin
          done   = 1'b1;
          code_c = FC_SECOND_LEVEL;
        end
      end else begin
        second_nxt = '0;
      end
    end

    if (!done) begin
      if (!smp.leak_ok) begin
        leak_nxt = sat_inc(leak_r);
        if (reached(leak_nxt, cfg.pin_persist_count)) begin
          code_c = FC_LEAK;
        end
      end else begin
        leak_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_fail_r  <= '0;
      gas_high_r  <= '0;
      temp_high_r <= '0;
      temp_fail_r <= '0;
      store_r     <= '0;
      second_r    <= '0;
      leak_r      <= '0;
    end else if (commit) begin
      gas_fail_r  <= gas_fail_nxt;
      gas_high_r  <= gas_high_nxt;
      temp_high_r <= temp_high_nxt;
      temp_fail_r <= temp_fail_nxt;
      store_r     <= store_nxt;
      second_r    <= second_nxt;
      leak_r      <= leak_nxt;
    end
  end

  assign code = code_c;

endmodule

[rtl/core/debounced_fault_monitor.sv]
// Top level of the debounced fault monitor: input register, checks, result register.
// Depends on dfm_pkg, dfm_cfg and dfm_check.
`timescale 1ns / 1ps

// One input transfer is one sample tick: gas ADC value, conversion timeout,
// temperature reading and three active-low pins (level, second level, leak).
// Seven saturating persistence counters qualify the faults in fixed priority
// (gas fail, gas high, temp fail, temp high, store low, second level, leak);
// the first counter that reaches its persistence count ends the tick and its
// code is reported with unsafe = 1, and counters of later checks hold. A clean
// reading clears its counters. Each tick yields exactly one result transfer.
// Throughput is one tick per clock while out_tready stays high; the result is
// offered after its input transfer passes the input register, the counter
// update and then the result register. While a result waits on out_tready the
// input register can still take one tick, so one tick of buffering sits on each
// side and in_tready drops only when both are full. Configuration writes take
// effect on the next edge and should be issued only while no tick is in flight.

module debounced_fault_monitor
  import dfm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // [9:0] gas_sample, [10] gas_timeout, [26:11] temp_reading,
  // [27] store_level_ok, [28] second_level_ok, [29] leak_ok, [31:30] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] unsafe, [3:1] fault_code, [7:4] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t        cfg;
  sample_t     smp_r;
  logic        smp_valid_r;
  logic        chk_fire;
  fault_code_t chk_code;
  fault_code_t code_r;
  logic        out_valid_r;

  dfm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage moves forward when the result register is empty or being drained.
  assign chk_fire  = smp_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !smp_valid_r || chk_fire;

  // Input register: payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      smp_r.gas_sample      <= in_tdata[GAS_W-1:0];
      smp_r.gas_timeout     <= in_tdata[GAS_W];
      smp_r.temp_reading    <= in_tdata[GAS_W+1 +: TEMP_W];
      smp_r.store_level_ok  <= in_tdata[GAS_W+1+TEMP_W];
      smp_r.second_level_ok <= in_tdata[GAS_W+2+TEMP_W];
      smp_r.leak_ok         <= in_tdata[GAS_W+3+TEMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_tready) begin
      smp_valid_r <= in_tvalid;
    end
  end

  dfm_check #(
    .COUNT_BITS (COUNT_BITS)
  ) u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .smp    (smp_r),
    .commit (chk_fire),
    .code   (chk_code)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (chk_fire) begin
      code_r <= chk_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (chk_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), code_r, (code_r != FC_SAFE)};

endmodule

[bench/tb_top.sv]
// Self-checking bench for debounced_fault_monitor: directed table, then random phases.
// Depends on dfm_pkg and the RTL of debounced_fault_monitor; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import dfm_pkg::*;

  localparam int CW = COUNT_BITS_DEF;

  // Scenario modes for the random traffic. A mode sticks for a run of ticks,
  // so persistence counters actually climb to their limits.
  typedef enum logic [1:0] {GM_CLEAN, GM_TIMEOUT, GM_HIGH} gas_mode_t;
  typedef enum logic [1:0] {TM_OK, TM_ZERO, TM_OVER, TM_HIGH} temp_mode_t;

  typedef struct packed {
    logic        unsafe;
    fault_code_t code;
  } verdict_t;

  // One row of the directed table: either a register write or a tick.
  // typed = 1 means the verdict is written in the row, not predicted.
  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    sample_t                s;
    logic                   typed;
    fault_code_t            code;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Bench-side copy of the monitor: config and the seven counters,
  // indexed by the fault code each one qualifies.
  cfg_t          mon_cfg;
  logic [CW-1:0] persist_cnt [1:7];

  verdict_t   pending_verdicts[$];
  int         err_count = 0;

  // Traffic knobs, set per phase.
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_off_cycles = 0;
  int         flip_pct = 8;
  logic       force_gas_fail = 1'b0;
  gas_mode_t  gas_mode = GM_CLEAN;
  temp_mode_t temp_mode = TM_OK;
  logic       store_bad = 1'b0;
  logic       second_bad = 1'b0;
  logic       leak_bad = 1'b0;

  row_t       plan_rows[$];

  debounced_fault_monitor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("debounced_fault_monitor test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturating bump, then the persistence compare (count >= limit).
  function automatic logic advance(fault_code_t c, logic [PERSIST_W-1:0] need);
    if (persist_cnt[c] != {CW{1'b1}}) persist_cnt[c] = persist_cnt[c] + 1'b1;
    return persist_cnt[c] >= need;
  endfunction

  // One tick through the priority chain. The first counter that qualifies
  // ends the tick, so later counters neither clear nor advance.
  function automatic fault_code_t judge_tick(sample_t s);
    if (s.gas_timeout) begin
      if (advance(FC_GAS_FAIL, mon_cfg.analog_persist_count)) return FC_GAS_FAIL;
    end else if (s.gas_sample >= mon_cfg.gas_high_limit) begin
      if (advance(FC_GAS_HIGH, mon_cfg.analog_persist_count)) return FC_GAS_HIGH;
    end else begin
      persist_cnt[FC_GAS_FAIL] = '0;
      persist_cnt[FC_GAS_HIGH] = '0;
    end

    // Read failure wins over high temperature.
    if (s.temp_reading > mon_cfg.temp_valid_max || s.temp_reading == '0) begin
      if (advance(FC_TEMP_FAIL, mon_cfg.analog_persist_count)) return FC_TEMP_FAIL;
    end else if (s.temp_reading > mon_cfg.temp_high_limit) begin
      if (advance(FC_TEMP_HIGH, mon_cfg.analog_persist_count)) return FC_TEMP_HIGH;
    end else begin
      persist_cnt[FC_TEMP_HIGH] = '0;
      persist_cnt[FC_TEMP_FAIL] = '0;
    end

    // Pins are active low.
    if (!s.store_level_ok) begin
      if (advance(FC_STORE_LOW, mon_cfg.pin_persist_count)) return FC_STORE_LOW;
    end else begin
      persist_cnt[FC_STORE_LOW] = '0;
    end

    if (!s.second_level_ok) begin
      if (advance(FC_SECOND_LEVEL, mon_cfg.pin_persist_count)) return FC_SECOND_LEVEL;
    end else begin
      persist_cnt[FC_SECOND_LEVEL] = '0;
    end

    if (!s.leak_ok) begin
      if (advance(FC_LEAK, mon_cfg.pin_persist_count)) return FC_LEAK;
    end else begin
      persist_cnt[FC_LEAK] = '0;
    end

    return FC_SAFE;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sample_t tick_of(logic [GAS_W-1:0] g, logic t, logic [TEMP_W-1:0] tr,
                                      logic st, logic sc, logic lk);
    sample_t s;
    s.gas_sample      = g;
    s.gas_timeout     = t;
    s.temp_reading    = tr;
    s.store_level_ok  = st;
    s.second_level_ok = sc;
    s.leak_ok         = lk;
    return s;
  endfunction

  function automatic row_t tick_row(sample_t s, logic typed, fault_code_t c);
    row_t r;
    r       = '0;
    r.s     = s;
    r.typed = typed;
    r.code  = c;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  // Random tick: mostly sticky scenarios with random content inside the
  // current thresholds, plus a slice of fully random noise.
  function automatic sample_t draw_tick();
    sample_t     s;
    logic [31:0] r, v, top;
    int          pick;
    r = $urandom;
    if ($urandom_range(99) < 8) begin
      s = r[IN_FIELDS_W-1:0];
    end else begin
      if ($urandom_range(99) < flip_pct) begin
        pick = $urandom_range(99);
        gas_mode = (pick < 55) ? GM_CLEAN : (pick < 75) ? GM_TIMEOUT : GM_HIGH;
      end
      if ($urandom_range(99) < flip_pct) begin
        pick = $urandom_range(99);
        temp_mode = (pick < 55) ? TM_OK : (pick < 65) ? TM_ZERO :
                    (pick < 80) ? TM_OVER : TM_HIGH;
      end
      if ($urandom_range(99) < flip_pct) store_bad = ~store_bad;
      if ($urandom_range(99) < flip_pct) second_bad = ~second_bad;
      if ($urandom_range(99) < flip_pct) leak_bad = ~leak_bad;

      s.gas_timeout = (gas_mode == GM_TIMEOUT);
      v = r;
      if (gas_mode == GM_CLEAN && mon_cfg.gas_high_limit != '0)
        v = $urandom_range(mon_cfg.gas_high_limit - 1, 0);
      else if (gas_mode == GM_HIGH)
        v = $urandom_range(1023, mon_cfg.gas_high_limit);
      s.gas_sample = v[GAS_W-1:0];

      // Top of the quiet temperature band.
      top = (mon_cfg.temp_high_limit < mon_cfg.temp_valid_max) ?
            mon_cfg.temp_high_limit : mon_cfg.temp_valid_max;
      case (temp_mode)
        TM_OK:   v = (top == 0) ? 1 : $urandom_range(top, 1);
        TM_ZERO: v = 0;
        TM_OVER: v = (mon_cfg.temp_valid_max == 16'hFFFF) ? 0 :
                     $urandom_range(65535, mon_cfg.temp_valid_max + 1);
        default: v = (mon_cfg.temp_valid_max > mon_cfg.temp_high_limit) ?
                     $urandom_range(mon_cfg.temp_valid_max, mon_cfg.temp_high_limit + 1) :
                     $urandom_range(65535, 0);
      endcase
      s.temp_reading    = v[TEMP_W-1:0];
      s.store_level_ok  = !store_bad;
      s.second_level_ok = !second_bad;
      s.leak_ok         = !leak_bad;
    end
    if (force_gas_fail) s.gas_timeout = 1'b1;
    return s;
  endfunction

  // Offer one tick; the verdict is queued at the transfer edge so queue order
  // is acceptance order. Inputs only change on the falling edge.
  task automatic send_tick(input sample_t s, input logic typed, input fault_code_t typed_code);
    fault_code_t code;
    verdict_t    v;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata = {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, s.leak_ok, s.second_level_ok,
                s.store_level_ok, s.temp_reading, s.gas_timeout, s.gas_sample};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    code = judge_tick(s);   // always run, keeps counters in step
    if (typed) code = typed_code;
    v.unsafe = (code != FC_SAFE);
    v.code   = code;
    pending_verdicts.push_back(v);
  endtask

  // Stop offering, let every queued verdict come back, then go on watching
  // for stray results.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Single-cycle register write; the bench copy changes with it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_GAS_HIGH_LIMIT:  mon_cfg.gas_high_limit       = val[GAS_W-1:0];
      CFG_TEMP_HIGH_LIMIT: mon_cfg.temp_high_limit      = val[TEMP_W-1:0];
      CFG_TEMP_VALID_MAX:  mon_cfg.temp_valid_max       = val[TEMP_W-1:0];
      CFG_ANALOG_PERSIST:  mon_cfg.analog_persist_count = val[PERSIST_W-1:0];
      CFG_PIN_PERSIST:     mon_cfg.pin_persist_count    = val[PERSIST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random phase: idle, program all five registers, set traffic shape,
  // optionally hold the receiver off, then stream n ticks.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] gh, th, tv, ap, pp,
                           input int idle_pct, stall_pct, flips, hold, n,
                           input logic gas_stuck);
    sample_t s;
    settle();
    write_reg(CFG_GAS_HIGH_LIMIT, gh);
    write_reg(CFG_TEMP_HIGH_LIMIT, th);
    write_reg(CFG_TEMP_VALID_MAX, tv);
    write_reg(CFG_ANALOG_PERSIST, ap);
    write_reg(CFG_PIN_PERSIST, pp);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    flip_pct       = flips;
    force_gas_fail = gas_stuck;
    if (hold > 0) begin
      @(posedge clk);
      hold_off_cycles = hold;
    end
    repeat (n) begin
      s = draw_tick();
      send_tick(s, 1'b0, FC_SAFE);
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    $display("MISMATCH @%0t: %s expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready changes on the falling edge. A requested hold-off is counted down
  // here, cycle by cycle, while the sender keeps pushing: the two internal
  // stages fill and in_tready must drop.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready = 1'b0;
      hold_off_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result transfer is matched against the oldest pending verdict.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("unexpected result, fault_code", -1, out_tdata[3:1]);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.unsafe)
          note_mismatch("unsafe", want.unsafe, out_tdata[0]);
        if (out_tdata[3:1] !== want.code)
          note_mismatch("fault_code", want.code, out_tdata[3:1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    mon_cfg.gas_high_limit       = GAS_HIGH_LIMIT_RST;
    mon_cfg.temp_high_limit      = TEMP_HIGH_LIMIT_RST;
    mon_cfg.temp_valid_max       = TEMP_VALID_MAX_RST;
    mon_cfg.analog_persist_count = ANALOG_PERSIST_RST;
    mon_cfg.pin_persist_count    = PIN_PERSIST_RST;
    for (int i = 1; i <= 7; i++) persist_cnt[i] = '0;

    // Reset-value behavior: one bad tick is far from any limit.
    plan_rows.push_back(tick_row(tick_of(100, 0, 500, 1, 1, 1), 1, FC_SAFE));
    plan_rows.push_back(tick_row(tick_of(1023, 1, 65535, 0, 0, 0), 1, FC_SAFE));
    // Limit 1: every bad tick qualifies, so the first bad check gives the code.
    plan_rows.push_back(cfg_row(CFG_ANALOG_PERSIST, 1));
    plan_rows.push_back(cfg_row(CFG_PIN_PERSIST, 1));
    plan_rows.push_back(tick_row(tick_of(100, 0, 500, 1, 1, 1), 1, FC_SAFE));
    plan_rows.push_back(tick_row(tick_of(1023, 1, 500, 1, 1, 1), 1, FC_GAS_FAIL));
    plan_rows.push_back(tick_row(tick_of(0, 1, 500, 1, 1, 1), 1, FC_GAS_FAIL));
    plan_rows.push_back(tick_row(tick_of(1023, 0, 500, 1, 1, 1), 1, FC_GAS_HIGH));
    plan_rows.push_back(tick_row(tick_of(768, 0, 500, 1, 1, 1), 1, FC_GAS_HIGH));
    plan_rows.push_back(tick_row(tick_of(767, 0, 0, 1, 1, 1), 1, FC_TEMP_FAIL));
    plan_rows.push_back(tick_row(tick_of(0, 0, 1201, 1, 1, 1), 1, FC_TEMP_FAIL));
    plan_rows.push_back(tick_row(tick_of(0, 0, 1200, 1, 1, 1), 1, FC_TEMP_HIGH));
    plan_rows.push_back(tick_row(tick_of(0, 0, 801, 1, 1, 1), 1, FC_TEMP_HIGH));
    plan_rows.push_back(tick_row(tick_of(0, 0, 800, 0, 1, 1), 1, FC_STORE_LOW));
    plan_rows.push_back(tick_row(tick_of(0, 0, 800, 1, 0, 1), 1, FC_SECOND_LEVEL));
    plan_rows.push_back(tick_row(tick_of(0, 0, 1, 1, 1, 0), 1, FC_LEAK));
    // Everything bad at once: gas timeout outranks the rest.
    plan_rows.push_back(tick_row(tick_of(0, 1, 65535, 0, 0, 0), 1, FC_GAS_FAIL));
    plan_rows.push_back(tick_row(tick_of(767, 0, 800, 1, 1, 1), 1, FC_SAFE));
    // Counts of 3/2: build-up, held counters behind a qualified fault,
    // and a fault that keeps reporting while its condition stays.
    plan_rows.push_back(cfg_row(CFG_ANALOG_PERSIST, 3));
    plan_rows.push_back(cfg_row(CFG_PIN_PERSIST, 2));
    repeat (4) plan_rows.push_back(tick_row(tick_of(0, 1, 0, 0, 0, 0), 0, FC_SAFE));
    plan_rows.push_back(tick_row(tick_of(1023, 0, 0, 0, 0, 0), 0, FC_SAFE));
    repeat (2) plan_rows.push_back(tick_row(tick_of(0, 0, 0, 0, 0, 0), 0, FC_SAFE));
    // Zero persistence: qualifies on the very first bad tick.
    plan_rows.push_back(cfg_row(CFG_ANALOG_PERSIST, 0));
    plan_rows.push_back(cfg_row(CFG_PIN_PERSIST, 0));
    plan_rows.push_back(tick_row(tick_of(0, 0, 500, 1, 1, 1), 1, FC_SAFE));
    plan_rows.push_back(tick_row(tick_of(0, 0, 500, 1, 1, 0), 1, FC_LEAK));
    plan_rows.push_back(tick_row(tick_of(0, 0, 500, 0, 1, 1), 1, FC_STORE_LOW));

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg) begin
        settle();
        write_reg(plan_rows[i].idx, plan_rows[i].val);
      end else begin
        send_tick(plan_rows[i].s, plan_rows[i].typed, plan_rows[i].code);
      end
    end

    //        gas   t_high t_valid ap   pp  idle stall flip hold   n  stuck
    // Reset settings again, back-to-back traffic.
    run_phase(768,  800,   1200,   20,  10,  0,   0,   5,   0,   150, 0);
    // Mid thresholds, bursty sender.
    run_phase(300,  500,   900,    3,   2,   55,  0,   8,   0,   200, 0);
    // Upper extremes, stalling receiver plus a long hold-off to back up input.
    run_phase(1023, 65535, 65535,  1,   1,   0,   55,  10,  60,  200, 0);
    // Lower extremes: gas is always high, temperature always failed.
    run_phase(0,    0,     0,      4,   3,   32,  32,  8,   0,   60,  0);
    // Largest counts with a stuck timeout: counter must pin, not wrap.
    run_phase(768,  800,   1200,   255, 255, 32,  32,  6,   0,   300, 1);
    run_phase(512,  1000,  2000,   6,   5,   32,  32,  4,   0,   200, 0);

    settle();
    if (err_count == 0) begin
      $display("debounced_fault_monitor test passed");
    end else begin
      $display("debounced_fault_monitor test failed");
    end
    $finish;
  end

endmodule
